### src/tma_pkg.sv
// ============================================================================
// tma_pkg: shared types and constants for the trailing moving average
// Sizes of the history ring, the running sum and the serial divider, the
// request payload types and the sequencer state codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tma_pkg;

    localparam int MAX_WINDOW = 32;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int WLEN_W = 6;                          // window_len register
    localparam int SLOT_W = $clog2(MAX_WINDOW);         // ring index
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);     // 1..MAX_WINDOW
    localparam int SUM_W  = VAL_W + SLOT_W;             // running window sum
    localparam int CNT_W  = $clog2(SUM_W + 1);          // divider step count

    localparam int PDATA_W = 32;
    localparam int PADDR_W = 2;

    localparam logic [PADDR_W-1:0] ADDR_WINDOW_LEN = PADDR_W'(0);
    localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST  = WLEN_W'(10);

    typedef struct packed {
        logic             series_start;
        logic [KEY_W-1:0] sample_key;
        logic [VAL_W-1:0] sample_value;
    } tma_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] avg_key;
        logic [VAL_W-1:0] avg_value;
    } tma_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tma_div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_UPD  = 3'b010,
        ST_DIV  = 3'b100
    } tma_state_t;

endpackage

`default_nettype wire

### src/tma_ram.sv
// ============================================================================
// tma_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/tma_div.sv
// ============================================================================
// tma_div: serial restoring divider for the window sum
// Divides the running sum by the window length, one quotient bit per cycle.
// The quotient holds until the next start.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tma_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tma_pkg::SUM_W-1:0]  dividend,
    input  wire logic [tma_pkg::LEN_W-1:0]  divisor,
    output logic      [tma_pkg::SUM_W-1:0]  quotient,
    output tma_pkg::tma_div_stat_t          stat
);

    logic [tma_pkg::SUM_W-1:0] q_reg;
    logic [tma_pkg::LEN_W-1:0] rem_reg;
    logic [tma_pkg::LEN_W-1:0] div_reg;
    logic [tma_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [tma_pkg::LEN_W:0]   rem_sh;
    logic [tma_pkg::LEN_W:0]   rem_diff;
    logic                      take;
    logic [tma_pkg::LEN_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[tma_pkg::SUM_W-1]};
        take     = (rem_sh >= {1'b0, div_reg});
        rem_diff = rem_sh - {1'b0, div_reg};
        // remainder stays below the divisor, so the top bit drops out
        rem_next = take ? rem_diff[tma_pkg::LEN_W-1:0] : rem_sh[tma_pkg::LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= tma_pkg::CNT_W'(tma_pkg::SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - tma_pkg::CNT_W'(1);
            if (cnt_reg == tma_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[tma_pkg::SUM_W-2:0], take};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### src/trailing_moving_average_top.sv
// ============================================================================
// trailing_moving_average_top: streaming trailing simple moving average
// Keeps the last samples in a ring RAM plus a running sum; each sample past a
// full window yields the mean of the preceding window, tagged with its key.
// ============================================================================
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_stall     | in_data  (series_start, key, value)
//  out      | out_valid / out_stall   | out_data (avg_key, avg_value)
//  cfg      | APB psel/penable/pready | window_len at byte address 0
//
//  A request without a result goes through the ring read, then update and
//  write back. A request with a result adds SUM_W divider steps, one
//  quotient bit per cycle, and then the load of the output register. A
//  finished result waits there while the next request is taken; a stalled
//  output holds the sequencer only when the next result is ready. Reset
//  clears the history and sets window_len to 10.
//
`timescale 1ns / 1ps
`default_nettype none

module trailing_moving_average_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire tma_pkg::tma_in_t             in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output tma_pkg::tma_out_t                 out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tma_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tma_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tma_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    tma_pkg::tma_state_t state_reg, state_next;

    logic [tma_pkg::WLEN_W-1:0] wlen_reg;
    logic [tma_pkg::SLOT_W-1:0] slot_reg;
    logic [tma_pkg::SUM_W-1:0]  sum_reg;
    logic [tma_pkg::LEN_W-1:0]  fill_reg;
    logic                       produce_reg;
    logic [tma_pkg::KEY_W-1:0]  key_reg;
    logic [tma_pkg::VAL_W-1:0]  val_reg;
    logic                       out_valid_reg;
    tma_pkg::tma_out_t          out_data_reg;

    logic [tma_pkg::LEN_W-1:0]  len_eff;
    logic [tma_pkg::SLOT_W-1:0] slot_eff;
    logic [tma_pkg::SUM_W-1:0]  sum_eff;
    logic [tma_pkg::LEN_W-1:0]  fill_eff;
    logic [tma_pkg::SLOT_W-1:0] old_addr;
    logic [tma_pkg::SLOT_W-1:0] slot_inc;
    logic                       in_acc;
    logic                       cfg_wr;
    logic                       out_free;
    logic                       ram_we;
    logic [tma_pkg::VAL_W-1:0]  ram_rdata;
    logic                       div_start;
    logic [tma_pkg::SUM_W-1:0]  div_q;
    tma_pkg::tma_div_stat_t     div_stat;

    assign in_acc   = in_valid && !in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr == tma_pkg::ADDR_WINDOW_LEN);
    assign out_free = !out_valid_reg || !out_stall;

    // zero means one, anything past the ring size saturates
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = tma_pkg::LEN_W'(1);
        end
        else if (int'(wlen_reg) > tma_pkg::MAX_WINDOW)
        begin
            len_eff = tma_pkg::LEN_W'(tma_pkg::MAX_WINDOW);
        end
        else
        begin
            len_eff = tma_pkg::LEN_W'(wlen_reg);
        end
    end

    // series start clears the history ahead of this sample
    assign slot_eff = in_data.series_start ? '0 : slot_reg;
    assign sum_eff  = in_data.series_start ? '0 : sum_reg;
    assign fill_eff = in_data.series_start ? '0 : fill_reg;

    // oldest sample of the window, wrapping around the ring
    always_comb
    begin
        if (int'(slot_eff) >= int'(len_eff))
        begin
            old_addr = tma_pkg::SLOT_W'(int'(slot_eff) - int'(len_eff));
        end
        else
        begin
            old_addr = tma_pkg::SLOT_W'(int'(slot_eff) + tma_pkg::MAX_WINDOW
                                        - int'(len_eff));
        end
    end

    assign slot_inc = (slot_reg == tma_pkg::SLOT_W'(tma_pkg::MAX_WINDOW - 1))
                      ? '0 : slot_reg + tma_pkg::SLOT_W'(1);

    assign ram_we    = (state_reg == tma_pkg::ST_UPD);
    assign div_start = (state_reg == tma_pkg::ST_UPD) && produce_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tma_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = tma_pkg::ST_UPD;
                end
            end
            tma_pkg::ST_UPD:
            begin
                state_next = produce_reg ? tma_pkg::ST_DIV : tma_pkg::ST_IDLE;
            end
            tma_pkg::ST_DIV:
            begin
                if (div_stat.done && out_free)
                begin
                    state_next = tma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tma_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != tma_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tma_pkg::ST_IDLE;
            wlen_reg      <= tma_pkg::WINDOW_LEN_RST;
            slot_reg      <= '0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            produce_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == tma_pkg::ST_DIV && div_stat.done && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                wlen_reg <= pwdata[tma_pkg::WLEN_W-1:0];
                slot_reg <= '0;
                sum_reg  <= '0;
                fill_reg <= '0;
            end
            else if (state_reg == tma_pkg::ST_IDLE && in_acc)
            begin
                slot_reg    <= slot_eff;
                sum_reg     <= sum_eff;
                fill_reg    <= fill_eff;
                produce_reg <= (fill_eff >= len_eff);
            end
            else if (state_reg == tma_pkg::ST_UPD)
            begin
                slot_reg <= slot_inc;
                if (produce_reg)
                begin
                    sum_reg <= sum_reg - tma_pkg::SUM_W'(ram_rdata)
                               + tma_pkg::SUM_W'(val_reg);
                end
                else
                begin
                    sum_reg  <= sum_reg + tma_pkg::SUM_W'(val_reg);
                    fill_reg <= fill_reg + tma_pkg::LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tma_pkg::ST_IDLE && in_acc)
        begin
            key_reg <= in_data.sample_key;
            val_reg <= in_data.sample_value;
        end
        if (state_reg == tma_pkg::ST_DIV && div_stat.done && out_free)
        begin
            out_data_reg.avg_key   <= key_reg;
            out_data_reg.avg_value <= div_q[tma_pkg::VAL_W-1:0];
        end
    end

    // read of the oldest entry is issued at accept; write-back follows in the next
    // cycle, so a full ring reads the old value before overwriting it
    tma_ram #(
        .WIDTH (tma_pkg::VAL_W),
        .DEPTH (tma_pkg::MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (val_reg),
        .raddr (old_addr),
        .rdata (ram_rdata)
    );

    // sum_reg still holds the pre-update window sum at start
    tma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len_eff),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr == tma_pkg::ADDR_WINDOW_LEN)
                       ? tma_pkg::PDATA_W'(wlen_reg) : '0;

endmodule

`default_nettype wire
